FILE: design/wsa_pkg.sv
// Shared types, constants and lookup functions for the WebSocket accept-key block.
// No dependencies; the scanner, datapath, sequencer and top import this package.
package wsa_pkg;

	localparam int HDR_LEN  = 18;
	localparam int GUID_LEN = 36;

	localparam logic [HDR_LEN*8-1:0]  HDR_TEXT  = "sec-websocket-key:";
	localparam logic [GUID_LEN*8-1:0] GUID_TEXT = "258EAFA5-E914-47DA-95CA-C5AB0DC85B11";

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_PAD = 8'h3D;

	// scanner phases
	typedef logic [1:0] phase_t;
	localparam phase_t PH_SCAN    = 2'd0;
	localparam phase_t PH_MATCH   = 2'd1;
	localparam phase_t PH_CAPTURE = 2'd2;
	localparam phase_t PH_DONE    = 2'd3;

	// result outcomes
	typedef logic [1:0] outcome_t;
	localparam outcome_t OC_ACCEPT  = 2'd0;
	localparam outcome_t OC_BADSIZE = 2'd1;
	localparam outcome_t OC_TRUNC   = 2'd2;
	localparam outcome_t OC_NODATA  = 2'd3;

	localparam logic [31:0] SHA_H0 = 32'h67452301;
	localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
	localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
	localparam logic [31:0] SHA_H3 = 32'h10325476;
	localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;
	localparam logic [31:0] SHA_K0 = 32'h5A827999;
	localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
	localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
	localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

	// scanner event for the byte on the input
	typedef struct packed {
		logic     hash_go;
		logic     err;
		outcome_t err_code;
	} wsa_ev_t;

	// controller to datapath
	typedef struct packed {
		logic scan_acc;
		logic start;
		logic err_load;
		logic issue;
		logic init_abcde;
		logic round;
		logic add;
		logic enc_load;
		logic shift;
	} wsa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic issue_last;
		logic round_last;
		logic more_blk;
		logic emit_last;
	} wsa_sts_t;

	function automatic logic [7:0] hdr_char(input logic [4:0] i);
		logic [7:0] r;
		int p;
		r = '0;
		p = HDR_LEN - 1 - int'(i);
		if (int'(i) < HDR_LEN) begin
			r = HDR_TEXT[8*p +: 8];
		end
		return r;
	endfunction

	function automatic logic [7:0] guid_char(input logic [5:0] i);
		logic [7:0] r;
		int p;
		r = '0;
		p = GUID_LEN - 1 - int'(i);
		if (int'(i) < GUID_LEN) begin
			r = GUID_TEXT[8*p +: 8];
		end
		return r;
	endfunction

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			r = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end else begin
			r = 8'h2F;
		end
		return r;
	endfunction

endpackage

FILE: design/wsa_in_if.sv
// Request byte channel: valid/ready with one request byte per word.
// No dependencies.
interface wsa_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_request;

	modport source(output valid, data_byte, end_of_request, input ready);
	modport sink(input valid, data_byte, end_of_request, output ready);
endinterface

FILE: design/wsa_out_if.sv
// Result channel: valid/ready with one outcome and accept character per word.
// No dependencies.
interface wsa_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] outcome;
	logic [7:0] accept_char;
	logic       run_last;

	modport source(output valid, outcome, accept_char, run_last, input ready);
	modport sink(input valid, outcome, accept_char, run_last, output ready);
endinterface

FILE: design/wsa_scan.sv
// Header scanner: newline tracking, header match, value capture and trim bounds.
// Holds the key store. Depends on wsa_pkg.
module wsa_scan import wsa_pkg::*; #(
	parameter int KEY_MAX     = 26,
	parameter int SCAN_WINDOW = 30,
	localparam int KW    = $clog2(SCAN_WINDOW),
	localparam int DEPTH = SCAN_WINDOW - 1,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          acc,
	input  logic [7:0]    data_byte,
	input  logic          end_of_request,
	output wsa_ev_t       ev,
	output logic [KW-1:0] key_start,
	output logic [KW-1:0] key_len,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0]    store [DEPTH];
	phase_t        phase_q, n_phase;
	logic [4:0]    hm_q, n_hm;
	logic [4:0]    bsn_q, n_bsn;
	logic          nl_q, n_nl;
	logic [KW-1:0] kl_q, n_kl;
	logic [KW-1:0] s_q, n_s;
	logic [KW-1:0] e_q, n_e;
	logic          allsp_q, n_allsp;
	logic          good_q, n_good;
	logic          wr_en;
	logic [7:0]    lb;
	logic [KW-1:0] klen;

	assign klen      = good_q ? (e_q - s_q) : '0;
	assign key_start = s_q;
	assign key_len   = klen;

	always_comb begin
		n_phase = phase_q;
		n_hm    = hm_q;
		n_bsn   = bsn_q;
		n_nl    = nl_q;
		n_kl    = kl_q;
		n_s     = s_q;
		n_e     = e_q;
		n_allsp = allsp_q;
		n_good  = good_q;
		wr_en   = 1'b0;
		ev      = '0;
		lb      = (data_byte >= 8'h41 && data_byte <= 8'h5A) ? data_byte + 8'd32 : data_byte;
		case (phase_q)
			PH_SCAN, PH_MATCH: begin
				if (data_byte == CH_LF) begin
					n_nl    = 1'b1;
					n_bsn   = '0;
					n_hm    = '0;
					n_phase = PH_MATCH;
				end else begin
					if (bsn_q != 5'd31) begin
						n_bsn = bsn_q + 5'd1;
					end
					if (phase_q == PH_MATCH) begin
						if (lb == hdr_char(hm_q)) begin
							n_hm = hm_q + 5'd1;
							if (n_hm == 5'(HDR_LEN)) begin
								n_phase = PH_CAPTURE;
								n_kl    = '0;
								n_s     = '0;
								n_e     = '0;
								n_allsp = 1'b1;
								n_good  = 1'b0;
							end
						end else begin
							n_phase = PH_SCAN;
						end
					end
				end
			end
			PH_CAPTURE: begin
				if (data_byte == CH_LF) begin
					n_phase = PH_DONE;
					if (klen == '0 || 6'(klen) > 6'(KEY_MAX)) begin
						ev.err      = 1'b1;
						ev.err_code = OC_BADSIZE;
					end else begin
						ev.hash_go = 1'b1;
					end
				end else if (kl_q >= KW'(SCAN_WINDOW - 1)) begin
					n_phase     = PH_DONE;
					ev.err      = 1'b1;
					ev.err_code = OC_TRUNC;
				end else begin
					wr_en = 1'b1;
					n_kl  = kl_q + 1'b1;
					// leading spaces move the start; any other byte ends that run
					if (allsp_q && data_byte == CH_SP) begin
						n_s = kl_q + 1'b1;
					end
					if (data_byte != CH_SP) begin
						n_allsp = 1'b0;
					end
					if (data_byte != CH_SP && data_byte != CH_CR) begin
						n_good = 1'b1;
						n_e    = kl_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (end_of_request && !ev.hash_go && !ev.err && n_phase != PH_DONE) begin
			ev.err = 1'b1;
			if (n_phase == PH_CAPTURE) begin
				ev.err_code = OC_TRUNC;
			end else if (n_nl && n_bsn < 5'(HDR_LEN)) begin
				ev.err_code = OC_TRUNC;
			end else begin
				ev.err_code = OC_NODATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN;
			hm_q    <= '0;
			bsn_q   <= '0;
			nl_q    <= 1'b0;
			kl_q    <= '0;
			s_q     <= '0;
			e_q     <= '0;
			allsp_q <= 1'b1;
			good_q  <= 1'b0;
		end else if (acc) begin
			if (end_of_request) begin
				phase_q <= PH_SCAN;
				hm_q    <= '0;
				bsn_q   <= '0;
				nl_q    <= 1'b0;
				kl_q    <= '0;
			end else begin
				phase_q <= n_phase;
				hm_q    <= n_hm;
				bsn_q   <= n_bsn;
				nl_q    <= n_nl;
				kl_q    <= n_kl;
			end
			s_q     <= n_s;
			e_q     <= n_e;
			allsp_q <= n_allsp;
			good_q  <= n_good;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && wr_en) begin
			store[kl_q[AW-1:0]] <= data_byte;
		end
		rd_data <= store[rd_addr];
	end

endmodule

FILE: design/wsa_dp.sv
// Hash datapath: message builder, SHA-1 round unit, base64 encoder, result payload.
// Depends on wsa_pkg; reads the key store through the scanner's read port.
module wsa_dp import wsa_pkg::*; #(
	parameter int SCAN_WINDOW = 30,
	localparam int KW    = $clog2(SCAN_WINDOW),
	localparam int DEPTH = SCAN_WINDOW - 1,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  wsa_cmd_t      cmd,
	input  wsa_ev_t       ev,
	input  logic [KW-1:0] key_start,
	input  logic [KW-1:0] key_len,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data,
	output wsa_sts_t      sts,
	output outcome_t      outcome,
	output logic [7:0]    accept_char,
	output logic          run_last
);

	logic [KW-1:0]      s_q, len_q;
	outcome_t           err_q;
	logic               errm_q;
	logic [6:0]         idx_q, idx_s1;
	logic               v_s1;
	logic [0:15][31:0]  sched_q;
	logic [31:0]        a_q, b_q, c_q, d_q, e_q;
	logic [31:0]        h_q [5];
	logic [6:0]         t_q;
	logic [161:0]       enc_q;
	logic [4:0]         cnt_q;

	logic [6:0]   mlen, end_idx, addr_sum;
	logic [9:0]   mbits;
	logic         two_blk;
	logic [7:0]   mb;
	logic [511:0] sflat;
	logic [31:0]  f, k, wnew, tmp;

	assign mlen     = 7'(len_q) + 7'(GUID_LEN);
	assign mbits    = {mlen, 3'b000};
	assign two_blk  = mlen >= 7'd56;
	assign end_idx  = two_blk ? 7'd127 : 7'd63;
	assign addr_sum = 7'(s_q) + idx_q;
	assign rd_addr  = addr_sum[AW-1:0];
	assign sflat    = sched_q;

	// padded message byte for the slot in stage 1
	always_comb begin
		if (idx_s1 < 7'(len_q)) begin
			mb = rd_data;
		end else if (idx_s1 < mlen) begin
			mb = guid_char(6'(idx_s1 - 7'(len_q)));
		end else if (idx_s1 == mlen) begin
			mb = 8'h80;
		end else if (idx_s1 == end_idx - 7'd1) begin
			mb = {6'b000000, mbits[9:8]};
		end else if (idx_s1 == end_idx) begin
			mb = mbits[7:0];
		end else begin
			mb = '0;
		end
	end

	always_comb begin
		if (t_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = SHA_K0;
		end else if (t_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = SHA_K1;
		end else if (t_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = SHA_K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = SHA_K3;
		end
		wnew = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
		wnew = {wnew[30:0], wnew[31]};
		tmp  = {a_q[26:0], a_q[31:27]} + f + e_q + k + sched_q[0];
	end

	assign sts.issue_last = idx_q[5:0] == 6'd63;
	assign sts.round_last = t_q == 7'd79;
	assign sts.more_blk   = two_blk && idx_q[6];
	assign sts.emit_last  = cnt_q == 5'd27;

	assign outcome     = errm_q ? err_q : OC_ACCEPT;
	assign accept_char = errm_q ? 8'h00 : (sts.emit_last ? CH_PAD : b64_char(enc_q[161:156]));
	assign run_last    = errm_q | sts.emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			errm_q <= 1'b0;
			idx_q  <= '0;
			t_q    <= '0;
			cnt_q  <= '0;
		end else begin
			v_s1 <= cmd.issue;
			if (cmd.start) begin
				errm_q <= 1'b0;
				idx_q  <= '0;
			end
			if (cmd.err_load) begin
				errm_q <= 1'b1;
			end
			if (cmd.issue) begin
				idx_q <= idx_q + 7'd1;
			end
			if (cmd.init_abcde) begin
				t_q <= '0;
			end else if (cmd.round) begin
				t_q <= t_q + 7'd1;
			end
			if (cmd.enc_load) begin
				cnt_q <= '0;
			end else if (cmd.shift) begin
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			s_q    <= key_start;
			len_q  <= key_len;
			h_q[0] <= SHA_H0;
			h_q[1] <= SHA_H1;
			h_q[2] <= SHA_H2;
			h_q[3] <= SHA_H3;
			h_q[4] <= SHA_H4;
		end
		if (cmd.err_load) begin
			err_q <= ev.err_code;
		end
		if (cmd.issue) begin
			idx_s1 <= idx_q;
		end
		if (v_s1) begin
			sched_q <= {sflat[503:0], mb};
		end else if (cmd.round) begin
			sched_q <= {sched_q[1:15], wnew};
		end
		if (cmd.init_abcde) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= tmp;
		end
		if (cmd.add) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
		if (cmd.enc_load) begin
			enc_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], 2'b00};
		end else if (cmd.shift) begin
			enc_q <= {enc_q[155:0], 6'b000000};
		end
	end

endmodule

FILE: design/wsa_ctrl.sv
// Sequencer: byte intake, block load, rounds, digest add and result emission.
// Depends on wsa_pkg; drives the datapath by command word, reads its status.
module wsa_ctrl import wsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  wsa_ev_t  ev,
	input  wsa_sts_t sts,
	output wsa_cmd_t cmd
);

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_ERR   = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_ADD   = 3'd5;
	localparam logic [2:0] ST_ENC   = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	logic [2:0] state_q, n_state;

	always_comb begin
		n_state   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_RUN: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.scan_acc = 1'b1;
					if (ev.hash_go) begin
						cmd.start = 1'b1;
						n_state   = ST_LOAD;
					end else if (ev.err) begin
						cmd.err_load = 1'b1;
						n_state      = ST_ERR;
					end
				end
			end
			ST_ERR: begin
				out_valid = 1'b1;
				if (out_ready) begin
					n_state = ST_RUN;
				end
			end
			ST_LOAD: begin
				cmd.issue = 1'b1;
				if (sts.issue_last) begin
					n_state = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.init_abcde = 1'b1;
				n_state        = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (sts.round_last) begin
					n_state = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				n_state = sts.more_blk ? ST_LOAD : ST_ENC;
			end
			ST_ENC: begin
				cmd.enc_load = 1'b1;
				n_state      = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.shift = 1'b1;
					if (sts.emit_last) begin
						n_state = ST_RUN;
					end
				end
			end
			default: n_state = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= n_state;
		end
	end

endmodule

FILE: design/websocket_handshake_accept_top.sv
// WebSocket accept-key generator: bytes in, Sec-WebSocket-Accept characters out.
// A byte that gives no result is taken while running; the next byte may follow at once.
// Key hash: per 64-byte SHA-1 block, byte loads, a drain, the rounds and a digest add; one or
// two blocks, then the encoder is loaded and 28 words go out at one per cycle under out ready.
// Error results appear in the cycle after the byte. Reset: arst_n clears all control state.
module websocket_handshake_accept_top import wsa_pkg::*; #(
	parameter int KEY_MAX     = 26,
	parameter int SCAN_WINDOW = 30
) (
	input logic      clk,
	input logic      arst_n,
	wsa_in_if.sink   req,
	wsa_out_if.source rsp
);

	localparam int KW    = $clog2(SCAN_WINDOW);
	localparam int DEPTH = SCAN_WINDOW - 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	wsa_ev_t       ev;
	wsa_cmd_t      cmd;
	wsa_sts_t      sts;
	logic [KW-1:0] key_start, key_len;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	// Sequencer: takes bytes while running, holds intake while hashing or emitting.
	wsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ev        (ev),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Scanner: header match and key capture, one word per accepted byte.
	wsa_scan #(
		.KEY_MAX     (KEY_MAX),
		.SCAN_WINDOW (SCAN_WINDOW)
	) u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.acc            (cmd.scan_acc),
		.data_byte      (req.data_byte),
		.end_of_request (req.end_of_request),
		.ev             (ev),
		.key_start      (key_start),
		.key_len        (key_len),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data)
	);

	// Hash datapath: builds the padded message, runs SHA-1, encodes base64.
	wsa_dp #(
		.SCAN_WINDOW (SCAN_WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.ev          (ev),
		.key_start   (key_start),
		.key_len     (key_len),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.sts         (sts),
		.outcome     (rsp.outcome),
		.accept_char (rsp.accept_char),
		.run_last    (rsp.run_last)
	);

	// Intake and emission never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("intake open while a result is pending");

	// Closing word of an accept run is the pad character.
	a_pad_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.outcome == OC_ACCEPT && rsp.run_last |-> rsp.accept_char == CH_PAD)
		else $error("accept run closed without pad character");

	// Error words stand alone and carry no character.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.outcome != OC_ACCEPT |-> rsp.run_last && rsp.accept_char == 8'h00)
		else $error("malformed error word");

endmodule

FILE: test/wsa_accept_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the WebSocket accept-key block: predicts results from request bytes.
// Depends on wsa_pkg for outcome codes and header/GUID text.
class wsa_accept_scoreboard;
	typedef struct {
		logic [1:0] outcome;
		logic [7:0] accept_char;
		logic       run_last;
	} accept_word_t;

	accept_word_t pending_words[$];
	int           mismatch_count;

	logic [1:0] scan_phase;
	int         match_pos;
	int         since_newline;
	bit         newline_seen;
	logic [7:0] key_bytes[32];
	int         key_len;

	function new();
		mismatch_count = 0;
		clear_request();
	endfunction

	function void clear_request();
		scan_phase = wsa_pkg::PH_SCAN;
		match_pos = 0;
		since_newline = 0;
		newline_seen = 0;
		key_len = 0;
	endfunction

	function void push_word(logic [1:0] oc, logic [7:0] ch, logic lst);
		accept_word_t w;
		w.outcome = oc;
		w.accept_char = ch;
		w.run_last = lst;
		pending_words.push_back(w);
	endfunction

	static function logic [31:0] rotl(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	static function logic [7:0] b64(int v);
		if (v < 26) return 8'(65 + v);
		if (v < 52) return 8'(97 + v - 26);
		if (v < 62) return 8'(48 + v - 52);
		return (v == 62) ? 8'h2B : 8'h2F;
	endfunction

	// Trim, hash key + GUID, and queue the accept string or a size error.
	function void hash_key();
		int s, e, n, mlen, nblk, t;
		logic [7:0] msg[128];
		logic [7:0] dig[20];
		logic [31:0] hv[5];
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, ee, f, k, tmp;
		logic [63:0] bits;
		int v, by, off;
		s = 0;
		e = key_len;
		while (s < e && key_bytes[s] == wsa_pkg::CH_SP) s++;
		while (e > s && (key_bytes[e-1] == wsa_pkg::CH_SP || key_bytes[e-1] == wsa_pkg::CH_CR))
			e--;
		n = e - s;
		if (n < 1 || n > 26) begin
			push_word(wsa_pkg::OC_BADSIZE, 8'h00, 1'b1);
			return;
		end
		for (int i = 0; i < 128; i++) msg[i] = 8'h00;
		for (int i = 0; i < n; i++) msg[i] = key_bytes[s + i];
		for (int i = 0; i < wsa_pkg::GUID_LEN; i++) msg[n + i] = wsa_pkg::guid_char(6'(i));
		mlen = n + wsa_pkg::GUID_LEN;
		msg[mlen] = 8'h80;
		nblk = (mlen + 8) / 64 + 1;
		bits = 64'(mlen) * 64'd8;
		for (int i = 0; i < 8; i++) msg[nblk * 64 - 1 - i] = bits[8*i +: 8];
		hv = '{wsa_pkg::SHA_H0, wsa_pkg::SHA_H1, wsa_pkg::SHA_H2, wsa_pkg::SHA_H3,
			wsa_pkg::SHA_H4};
		for (int bl = 0; bl < nblk; bl++) begin
			for (t = 0; t < 16; t++)
				w[t] = {msg[64*bl+4*t], msg[64*bl+4*t+1], msg[64*bl+4*t+2], msg[64*bl+4*t+3]};
			a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3]; ee = hv[4];
			for (t = 0; t < 80; t++) begin
				if (t >= 16)
					w[t%16] = rotl(w[(t-3)%16] ^ w[(t-8)%16] ^ w[(t-14)%16] ^ w[t%16], 1);
				if (t < 20) begin f = (b & c) | (~b & d); k = wsa_pkg::SHA_K0; end
				else if (t < 40) begin f = b ^ c ^ d; k = wsa_pkg::SHA_K1; end
				else if (t < 60) begin f = (b & c) | (b & d) | (c & d); k = wsa_pkg::SHA_K2; end
				else begin f = b ^ c ^ d; k = wsa_pkg::SHA_K3; end
				tmp = rotl(a, 5) + f + ee + k + w[t%16];
				ee = d; d = c; c = rotl(b, 30); b = a; a = tmp;
			end
			hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d; hv[4] += ee;
		end
		for (int i = 0; i < 20; i++) dig[i] = 8'(hv[i/4] >> (24 - 8 * (i % 4)));
		for (int i = 0; i < 27; i++) begin
			by = (6 * i) / 8;
			off = (6 * i) % 8;
			v = (int'(dig[by]) << 8) | ((by + 1 < 20) ? int'(dig[by+1]) : 0);
			push_word(wsa_pkg::OC_ACCEPT, b64((v >> (10 - off)) & 63), 1'b0);
		end
		push_word(wsa_pkg::OC_ACCEPT, wsa_pkg::CH_PAD, 1'b1);
	endfunction

	// Note one accepted request byte and queue the results it causes.
	function void note_byte(logic [7:0] db, logic eor);
		logic [7:0] lb;
		int prior_count;
		prior_count = pending_words.size();
		if (scan_phase == wsa_pkg::PH_SCAN || scan_phase == wsa_pkg::PH_MATCH) begin
			if (db == wsa_pkg::CH_LF) begin
				newline_seen = 1;
				since_newline = 0;
				match_pos = 0;
				scan_phase = wsa_pkg::PH_MATCH;
			end else begin
				lb = (db >= 8'h41 && db <= 8'h5A) ? db + 8'h20 : db;
				if (since_newline < 31) since_newline++;
				if (scan_phase == wsa_pkg::PH_MATCH) begin
					if (match_pos < wsa_pkg::HDR_LEN &&
					    lb == wsa_pkg::hdr_char(5'(match_pos))) begin
						match_pos++;
						if (match_pos == wsa_pkg::HDR_LEN) begin
							scan_phase = wsa_pkg::PH_CAPTURE;
							key_len = 0;
						end
					end else begin
						scan_phase = wsa_pkg::PH_SCAN;
					end
				end
			end
		end else if (scan_phase == wsa_pkg::PH_CAPTURE) begin
			if (db == wsa_pkg::CH_LF) begin
				hash_key();
				scan_phase = wsa_pkg::PH_DONE;
			end else if (key_len >= 29) begin
				push_word(wsa_pkg::OC_TRUNC, 8'h00, 1'b1);
				scan_phase = wsa_pkg::PH_DONE;
			end else begin
				key_bytes[key_len] = db;
				key_len++;
			end
		end
		if (eor) begin
			if (pending_words.size() == prior_count && scan_phase != wsa_pkg::PH_DONE) begin
				if (scan_phase == wsa_pkg::PH_CAPTURE ||
				    (newline_seen && since_newline < wsa_pkg::HDR_LEN))
					push_word(wsa_pkg::OC_TRUNC, 8'h00, 1'b1);
				else
					push_word(wsa_pkg::OC_NODATA, 8'h00, 1'b1);
			end
			clear_request();
		end
	endfunction

	// Compare one accepted result word with the oldest expectation.
	function void check_word(logic [1:0] oc, logic [7:0] ch, logic lst);
		accept_word_t w;
		if (pending_words.size() == 0) begin
			$error("unexpected result word outcome=%0d char=%h", oc, ch);
			mismatch_count++;
			return;
		end
		w = pending_words.pop_front();
		if (oc !== w.outcome) begin
			$error("outcome: expected %0d actual %0d", w.outcome, oc);
			mismatch_count++;
		end
		if (ch !== w.accept_char) begin
			$error("accept_char: expected %h actual %h", w.accept_char, ch);
			mismatch_count++;
		end
		if (lst !== w.run_last) begin
			$error("run_last: expected %0d actual %0d", w.run_last, lst);
			mismatch_count++;
		end
	endfunction
endclass

FILE: test/websocket_handshake_accept_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for websocket_handshake_accept_top: directed and random requests.
// Depends on wsa_pkg, wsa_in_if, wsa_out_if and wsa_accept_scoreboard.
module websocket_handshake_accept_top_tb;
	import wsa_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;

	wsa_in_if  req();
	wsa_out_if rsp();

	websocket_handshake_accept_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	wsa_accept_scoreboard accept_sb;
	bit   idle_off;      // long stretch with no idling on either side
	int   quiet_cycles;
	int   byte_count;
	byte  req_text[$];   // bytes of the request being built

	// Sample both channels at the rising edge; any word moved resets the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				accept_sb.note_byte(req.data_byte, req.end_of_request);
			end
			if (rsp.valid && rsp.ready) begin
				accept_sb.check_word(rsp.outcome, rsp.accept_char, rsp.run_last);
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles > STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Random back-pressure on the result side, changed at the falling edge.
	always @(negedge clk) begin
		rsp.ready <= idle_off || ($urandom_range(99) >= 22);
	end

	// Send one byte: idle at random, hold until accepted.
	task automatic send_byte(input logic [7:0] db, input logic eor);
		while (!idle_off && $urandom_range(99) < 22) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1;
		req.data_byte <= db;
		req.end_of_request <= eor;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
		byte_count++;
	endtask

	// Send the bytes built up in req_text, the last one marked end of request.
	task automatic send_request();
		for (int i = 0; i < req_text.size(); i++)
			send_byte(req_text[i], i == req_text.size() - 1);
		req_text.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) req_text.push_back(s[i]);
	endtask

	// Header name with random letter case.
	task automatic add_header();
		string h;
		byte c;
		h = "sec-websocket-key:";
		for (int i = 0; i < h.len(); i++) begin
			c = h[i];
			if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'h20;
			req_text.push_back(c);
		end
	endtask

	// Random key of n base64-ish characters.
	task automatic add_key(input int n);
		string al;
		al = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
		for (int i = 0; i < n; i++) req_text.push_back(al[$urandom_range(al.len() - 1)]);
	endtask

	task automatic add_noise(input int n);
		for (int i = 0; i < n; i++) req_text.push_back($urandom_range(255));
	endtask

	// Well-formed request with random padding and key length.
	task automatic good_request(input int klen);
		add_text("GET / HTTP/1.1\r\n");
		if ($urandom_range(1)) add_text("Host: x\r\n");
		add_header();
		repeat ($urandom_range(2)) req_text.push_back(" ");
		add_key(klen);
		repeat ($urandom_range(2)) req_text.push_back(" ");
		if ($urandom_range(3)) req_text.push_back(8'h0D);
		req_text.push_back(8'h0A);
		add_noise($urandom_range(3));
	endtask

	initial begin
		int kind;
		accept_sb = new();
		req.valid = 0;
		req.data_byte = 0;
		req.end_of_request = 0;
		rsp.ready = 0;
		idle_off = 0;
		quiet_cycles = 0;
		byte_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: shortest and longest keys, size error, newline inside the
		// header with an unterminated value, overlong value, short tail, no data.
		add_text("\nSec-WebSocket-Key:A\n");
		send_request();
		add_text("\nsec-websocket-key:"); add_key(26); add_text("\r\n");
		send_request();
		add_text("\nsec-websocket-key: \r\n");
		send_request();
		add_text("\nsec-web\nsec-websocket-key:abc");
		send_request();
		add_text("\nsec-websocket-key:"); add_key(30);
		send_request();
		add_text("\nshort");
		send_request();
		req_text.push_back(8'hFF); req_text.push_back(8'h00);
		send_request();

		// Random: mostly well-formed requests, some broken, some noise.
		while (byte_count < 170) begin
			idle_off = ($urandom_range(9) == 0);
			kind = $urandom_range(99);
			if (kind < 60) begin
				good_request($urandom_range(26, 1));
			end else if (kind < 72) begin
				add_text("\nsec-websocket-key:");
				add_key($urandom_range(34));
				if ($urandom_range(1)) add_text("\n");
			end else if (kind < 84) begin
				add_noise($urandom_range(5));
				add_text("\n");
				add_header();
				req_text = req_text[0:$ - $urandom_range(17, 1)];
			end else begin
				add_noise($urandom_range(40, 1));
				if ($urandom_range(1)) add_text("\n");
			end
			send_request();
		end
		req.valid <= 0;
		idle_off = 0;

		// Drain, then allow for the hash latency before judging.
		while (accept_sb.pending_words.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (accept_sb.mismatch_count == 0 && accept_sb.pending_words.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
